// ===== sv/mlfm_pkg.sv =====
// shared constants and types for the multiplayer link frame master
// no dependencies
`default_nettype none

package mlfm_pkg;

    localparam int WORD_W = 16;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int FRAME_WORDS_DEF = 8;
    localparam int PEER_COUNT_DEF  = 4;

    localparam logic [31:0] PKT_MAGIC      = 32'h4d50_4b31;
    localparam logic [15:0] PKT_LEN_BYTES  = 16'd40;
    localparam logic [15:0] TOK_MASTER     = 16'h8FFF;
    localparam logic [15:0] TOK_SLAVE      = 16'hB9A0;
    localparam logic [15:0] TOK_NOT_READY  = 16'hFFFF;
    localparam logic [7:0]  RUN_LIMIT_RST  = 8'd18;
    localparam logic [7:0]  RUN_SAT        = 8'd255;

    localparam logic [1:0] OP_XFER = 2'd0;
    localparam logic [1:0] OP_HDR  = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;

    // config register index (byte address bit 2)
    localparam logic CFG_RUN_LIMIT = 1'b0;

    // packet staging and queue write control
    typedef struct packed {
        logic        clear;
        logic        we;
        logic        commit;
        logic [2:0]  widx;
        logic [15:0] value;
        logic [1:0]  peer;
    } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/multiplayer_link_frame_master.sv =====
// Master side of a multiplayer serial link bridged to a network. A master
// transfer gives one result word, or 1 + FRAME_WORDS when a frame with data
// is broadcast, and the next transfer is taken as the last result word
// leaves, so the output serializer paces the transfers. Packet words
// (opcodes 1 and 2) produce nothing and are taken every cycle while the
// serializer is not holding the input. Peer queue rows are read from
// registered memories addressed with the next head, so each row is ready before use.
// depends on mlfm_pkg, mlfm_cfg, mlfm_queue
`default_nettype none

module multiplayer_link_frame_master
    import mlfm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int FRAME_WORDS = FRAME_WORDS_DEF,
    parameter int PEER_COUNT  = PEER_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] value,
    input  wire logic [1:0]  peer_index,
    input  wire logic [31:0] flags_word,
    input  wire logic [31:0] header_word,
    input  wire logic [15:0] packet_length,
    input  wire logic [2:0]  word_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] multi0,
    output logic      [15:0] multi1,
    output logic      [15:0] multi2,
    output logic      [15:0] multi3,
    output logic             send_valid,
    output logic      [15:0] send_state,
    output logic             send_with_data,
    output logic      [15:0] payload_word,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W  = $clog2(FRAME_WORDS + 1);
    localparam int ROW_W  = FRAME_WORDS * WORD_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [OFF_W-1:0] FW_C    = OFF_W'(FRAME_WORDS);

    typedef enum logic [1:0] {
        PH_PREINIT   = 2'd0,
        PH_HANDSHAKE = 2'd1,
        PH_CONNECTED = 2'd2,
        PH_SPARE     = 2'd3
    } phase_t;

    logic [7:0] run_limit;

    mlfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .run_limit (run_limit)
    );

    phase_t             phase_reg, phase_next;
    logic [15:0]        prs_reg [4];
    logic [15:0]        prs_next [4];
    logic [15:0]        cs_reg, cs_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [7:0]         run_reg, run_next;
    logic [HEAD_W-1:0]  head_reg [PEER_COUNT];
    logic [HEAD_W-1:0]  head_next [PEER_COUNT];
    logic [CNT_W-1:0]   cnt_reg [PEER_COUNT];
    logic [CNT_W-1:0]   cnt_next [PEER_COUNT];
    logic               snd_reg [PEER_COUNT];
    logic               snd_next [PEER_COUNT];
    logic [15:0]        frame_reg [FRAME_WORDS];
    logic [15:0]        frame_next [FRAME_WORDS];
    logic               nz_reg, nz_next;
    logic [15:0]        link_reg [4];
    logic [15:0]        link_next [4];
    logic               rxa_reg, rxa_next;
    logic [1:0]         rxp_reg, rxp_next;

    logic               busy_reg, busy_next;
    logic [OFF_W-1:0]   idx_reg, idx_next;
    logic               sv_reg, sv_next;
    logic [15:0]        st_reg, st_next;
    logic               wd_reg, wd_next;

    stage_ctrl_t        ctrl;
    logic [HEAD_W-1:0]  tail;
    logic [PEER_COUNT-1:0][HEAD_W-1:0] head_bus;
    logic [PEER_COUNT-1:0][ROW_W-1:0]  rd_row;

    logic               last_now;
    logic               accept;

    mlfm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_WORDS (FRAME_WORDS),
        .PEER_COUNT  (PEER_COUNT),
        .HEAD_W      (HEAD_W)
    ) u_queue (
        .clk       (clk),
        .ctrl      (ctrl),
        .tail      (tail),
        .head_next (head_bus),
        .rd_row    (rd_row)
    );

    always_comb
    begin
        for (int p = 0; p < PEER_COUNT; p++)
            head_bus[p] = head_next[p];
    end

    assign last_now = (idx_reg == (wd_reg ? FW_C : '0));
    assign in_ready = !busy_reg || (out_ready && last_now);
    assign accept   = in_valid && in_ready;

    assign out_valid      = busy_reg;
    assign multi0         = link_reg[0];
    assign multi1         = link_reg[1];
    assign multi2         = link_reg[2];
    assign multi3         = link_reg[3];
    assign send_valid     = sv_reg;
    assign send_state     = st_reg;
    assign send_with_data = wd_reg;
    assign last           = last_now;

    always_comb
    begin
        payload_word = '0;
        for (int k = 0; k < FRAME_WORDS; k++)
        begin
            if (int'(idx_reg) == k + 1)
                payload_word = frame_reg[k];
        end
    end

    // tail slot of the peer with a pending packet
    always_comb
    begin
        logic [CNT_W:0] sum;
        sum = '0;
        for (int p = 0; p < PEER_COUNT; p++)
        begin
            if (rxp_reg == 2'(p))
                sum = {{(CNT_W + 1 - HEAD_W){1'b0}}, head_reg[p]} + {1'b0, cnt_reg[p]};
        end
        if (sum >= {1'b0, DEPTH_C})
            sum = sum - {1'b0, DEPTH_C};
        tail = sum[HEAD_W-1:0];
    end

    always_comb
    begin
        logic        emit;
        logic [15:0] w;
        logic [OFF_W-1:0] pos;

        phase_next = phase_reg;
        cs_next    = cs_reg;
        off_next   = off_reg;
        run_next   = run_reg;
        nz_next    = nz_reg;
        rxa_next   = rxa_reg;
        rxp_next   = rxp_reg;
        for (int i = 0; i < 4; i++)
        begin
            prs_next[i]  = prs_reg[i];
            link_next[i] = link_reg[i];
        end
        for (int p = 0; p < PEER_COUNT; p++)
        begin
            head_next[p] = head_reg[p];
            cnt_next[p]  = cnt_reg[p];
            snd_next[p]  = snd_reg[p];
        end
        for (int k = 0; k < FRAME_WORDS; k++)
            frame_next[k] = frame_reg[k];

        busy_next = busy_reg;
        idx_next  = idx_reg;
        sv_next   = sv_reg;
        st_next   = st_reg;
        wd_next   = wd_reg;

        ctrl  = '0;
        ctrl.widx  = word_index;
        ctrl.value = value;
        ctrl.peer  = rxp_reg;
        emit  = 1'b0;
        w     = '0;
        pos   = off_reg - OFF_W'(1);

        if (busy_reg && out_ready)
        begin
            if (last_now)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + OFF_W'(1);
        end

        if (accept)
        begin
            case (opcode)
                OP_XFER:
                begin
                    emit    = 1'b1;
                    sv_next = 1'b0;
                    st_next = '0;
                    wd_next = 1'b0;
                    link_next[0] = value;
                    unique case (phase_reg)
                        PH_PREINIT:
                        begin
                            if (value == TOK_SLAVE)
                            begin
                                phase_next = PH_HANDSHAKE;
                                for (int i = 1; i < PEER_COUNT; i++)
                                    link_next[i] = '0;
                                sv_next = 1'b1;
                                st_next = {14'd0, PH_HANDSHAKE};
                            end
                        end
                        PH_HANDSHAKE:
                        begin
                            for (int i = 1; i < PEER_COUNT; i++)
                                link_next[i] = (prs_reg[i] == {14'd0, PH_HANDSHAKE}) ?
                                               TOK_SLAVE : TOK_NOT_READY;
                            sv_next = 1'b1;
                            st_next = {14'd0, PH_HANDSHAKE};
                            if (value == TOK_MASTER)
                            begin
                                phase_next = PH_CONNECTED;
                                st_next    = {14'd0, PH_CONNECTED};
                                cs_next    = '0;
                                off_next   = '0;
                                run_next   = '0;
                                for (int p = 1; p < PEER_COUNT; p++)
                                begin
                                    cnt_next[p]  = '0;
                                    head_next[p] = '0;
                                end
                                // pending packets only ever belong to nonzero peers
                                if (rxp_reg != 2'd0)
                                    rxa_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            logic quit;
                            quit = 1'b0;
                            if (value != TOK_SLAVE)
                                run_next = '0;
                            else
                            begin
                                if (run_reg != RUN_SAT)
                                    run_next = run_reg + 8'd1;
                                if (run_next > run_limit)
                                begin
                                    phase_next = PH_HANDSHAKE;
                                    quit = 1'b1;
                                end
                            end
                            if (!quit)
                            begin
                                if (off_reg == '0)
                                begin
                                    for (int p = 1; p < PEER_COUNT; p++)
                                    begin
                                        link_next[p] = cs_reg;
                                        snd_next[p]  = (cnt_reg[p] != '0);
                                    end
                                    off_next = OFF_W'(1);
                                    cs_next  = '0;
                                    nz_next  = 1'b0;
                                end
                                else
                                begin
                                    for (int k = 0; k < FRAME_WORDS; k++)
                                        if (int'(pos) == k)
                                            frame_next[k] = value;
                                    nz_next = nz_reg || (value != '0);
                                    cs_next = cs_reg + value;
                                    for (int p = 1; p < PEER_COUNT; p++)
                                    begin
                                        w = '0;
                                        for (int k = 0; k < FRAME_WORDS; k++)
                                            if (int'(pos) == k)
                                                w = rd_row[p][k*WORD_W +: WORD_W];
                                        if (snd_reg[p])
                                        begin
                                            cs_next      = cs_next + w;
                                            link_next[p] = w;
                                        end
                                        else
                                            link_next[p] = '0;
                                    end
                                    if (off_reg < FW_C)
                                        off_next = off_reg + OFF_W'(1);
                                    else
                                    begin
                                        // frame done: dequeue and broadcast
                                        off_next = '0;
                                        for (int p = 1; p < PEER_COUNT; p++)
                                        begin
                                            if (snd_reg[p] && cnt_reg[p] != '0)
                                            begin
                                                cnt_next[p]  = cnt_reg[p] - CNT_W'(1);
                                                head_next[p] =
                                                    (int'(head_reg[p]) == QUEUE_DEPTH - 1) ?
                                                    '0 : head_reg[p] + HEAD_W'(1);
                                            end
                                        end
                                        sv_next = 1'b1;
                                        st_next = {14'd0, PH_CONNECTED};
                                        wd_next = nz_next;
                                    end
                                end
                            end
                        end
                    endcase
                end
                OP_HDR:
                begin
                    if (int'(peer_index) < PEER_COUNT && packet_length == PKT_LEN_BYTES &&
                        header_word == PKT_MAGIC)
                    begin
                        logic room;
                        room = 1'b0;
                        prs_next[peer_index] = flags_word[15:0];
                        if (rxa_reg && rxp_reg == peer_index)
                            rxa_next = 1'b0;
                        for (int p = 0; p < PEER_COUNT; p++)
                            if (peer_index == 2'(p))
                                room = (cnt_reg[p] < DEPTH_C);
                        if (peer_index != 2'd0 && flags_word[31] && room)
                        begin
                            ctrl.clear = 1'b1;
                            rxa_next   = 1'b1;
                            rxp_next   = peer_index;
                        end
                    end
                end
                OP_DATA:
                begin
                    if (rxa_reg && int'(word_index) < FRAME_WORDS)
                    begin
                        ctrl.we = 1'b1;
                        if (int'(word_index) == FRAME_WORDS - 1)
                        begin
                            ctrl.commit = 1'b1;
                            rxa_next    = 1'b0;
                            for (int p = 0; p < PEER_COUNT; p++)
                                if (rxp_reg == 2'(p) && cnt_reg[p] < DEPTH_C)
                                    cnt_next[p] = cnt_reg[p] + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREINIT;
            cs_reg    <= '0;
            off_reg   <= '0;
            run_reg   <= '0;
            nz_reg    <= 1'b0;
            rxa_reg   <= 1'b0;
            rxp_reg   <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            sv_reg    <= 1'b0;
            st_reg    <= '0;
            wd_reg    <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                prs_reg[i]  <= '0;
                link_reg[i] <= '0;
            end
            for (int p = 0; p < PEER_COUNT; p++)
            begin
                head_reg[p] <= '0;
                cnt_reg[p]  <= '0;
                snd_reg[p]  <= 1'b0;
            end
            for (int k = 0; k < FRAME_WORDS; k++)
                frame_reg[k] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cs_reg    <= cs_next;
            off_reg   <= off_next;
            run_reg   <= run_next;
            nz_reg    <= nz_next;
            rxa_reg   <= rxa_next;
            rxp_reg   <= rxp_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            sv_reg    <= sv_next;
            st_reg    <= st_next;
            wd_reg    <= wd_next;
            for (int i = 0; i < 4; i++)
            begin
                prs_reg[i]  <= prs_next[i];
                link_reg[i] <= link_next[i];
            end
            for (int p = 0; p < PEER_COUNT; p++)
            begin
                head_reg[p] <= head_next[p];
                cnt_reg[p]  <= cnt_next[p];
                snd_reg[p]  <= snd_next[p];
            end
            for (int k = 0; k < FRAME_WORDS; k++)
                frame_reg[k] <= frame_next[k];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mlfm_cfg.sv =====
// apb configuration register: handshake run limit
// depends on mlfm_pkg
`default_nettype none

module mlfm_cfg
    import mlfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  run_limit
);

    logic [7:0] limit_reg;

    assign pready    = 1'b1;
    assign run_limit = limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RUN_LIMIT_RST;
        end
        else if (psel && penable && pwrite && paddr[2] == CFG_RUN_LIMIT)
        begin
            limit_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_RUN_LIMIT)
        begin
            prdata = {24'd0, limit_reg};
        end
    end

endmodule

`default_nettype wire

// ===== sv/mlfm_queue.sv =====
// peer packet queues: staging row for the packet being received and one
// ring memory per peer, one frame row per entry; depends on mlfm_pkg
`default_nettype none

module mlfm_queue
    import mlfm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int FRAME_WORDS = FRAME_WORDS_DEF,
    parameter int PEER_COUNT  = PEER_COUNT_DEF,
    parameter int HEAD_W      = 7
)
(
    input  wire logic                                      clk,
    input  wire stage_ctrl_t                               ctrl,
    input  wire logic [HEAD_W-1:0]                         tail,
    input  wire logic [PEER_COUNT-1:0][HEAD_W-1:0]         head_next,
    output logic      [PEER_COUNT-1:0][FRAME_WORDS*WORD_W-1:0] rd_row
);

    localparam int ROW_W = FRAME_WORDS * WORD_W;

    logic [WORD_W-1:0] stage_reg [FRAME_WORDS];
    logic [ROW_W-1:0]  row_wr;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FRAME_WORDS; k++)
        begin
            if (ctrl.clear)
                stage_reg[k] <= '0;
            else if (ctrl.we && k == int'(ctrl.widx))
                stage_reg[k] <= ctrl.value;
        end
    end

    // the committing word goes straight into the row
    always_comb
    begin
        for (int k = 0; k < FRAME_WORDS; k++)
        begin
            row_wr[k*WORD_W +: WORD_W] = (ctrl.we && k == int'(ctrl.widx)) ?
                                         ctrl.value : stage_reg[k];
        end
    end

    for (genvar p = 0; p < PEER_COUNT; p++)
    begin : g_peer
        logic [ROW_W-1:0] mem [QUEUE_DEPTH];
        logic [ROW_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (ctrl.commit && ctrl.peer == 2'(p))
                mem[tail] <= row_wr;
            rd_reg <= mem[head_next[p]];
        end

        assign rd_row[p] = rd_reg;
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for multiplayer_link_frame_master: drives transfer and packet words,
// predicts link registers and broadcast words, checks every result word in order
// depends on mlfm_pkg and the multiplayer_link_frame_master rtl
`timescale 1ns / 1ps

module tb;
    import mlfm_pkg::*;

    localparam logic [1:0] PH_PREINIT   = 2'd0;
    localparam logic [1:0] PH_HANDSHAKE = 2'd1;
    localparam logic [1:0] PH_CONNECTED = 2'd2;
    localparam logic [1:0] OP_RSVD      = 2'd3;
    localparam logic [2:0] ADDR_RUN_LIMIT = 3'd0;
    localparam int QD = 128;
    localparam int FW = 8;

    typedef struct {
        logic [15:0] multi [4];
        logic        sv;
        logic [15:0] st;
        logic        wd;
        logic [15:0] pw;
        logic        lst;
    } link_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] value;
    logic [1:0]  peer_index;
    logic [31:0] flags_word;
    logic [31:0] header_word;
    logic [15:0] packet_length;
    logic [2:0]  word_index;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] multi0, multi1, multi2, multi3;
    logic        send_valid;
    logic [15:0] send_state;
    logic        send_with_data;
    logic [15:0] payload_word;
    logic        last;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multiplayer_link_frame_master u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .value(value), .peer_index(peer_index),
        .flags_word(flags_word), .header_word(header_word),
        .packet_length(packet_length), .word_index(word_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .multi0(multi0), .multi1(multi1), .multi2(multi2), .multi3(multi3),
        .send_valid(send_valid), .send_state(send_state),
        .send_with_data(send_with_data), .payload_word(payload_word), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predicted link state
    logic [7:0]  run_limit;
    logic [1:0]  phase;
    logic [15:0] peer_state [4];
    logic [15:0] frame_sum;
    logic [3:0]  frame_pos;
    logic [7:0]  slave_run;
    logic [15:0] pkt_store [4][QD][FW];
    logic [6:0]  q_head [4];
    logic [7:0]  q_count [4];
    logic        peer_tx [4];
    logic [15:0] tx_frame [FW];
    logic        tx_nonzero;
    logic [15:0] link_reg [4];
    logic        pkt_open;
    logic [1:0]  pkt_peer;

    link_word_t  expected_words [$];
    bit          failed;
    int          burst_left;
    int          rx_mode;
    int          rx_cycles;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (rx_cycles == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            rx_cycles <= $urandom_range(10, 80);
        end else begin
            rx_cycles <= rx_cycles - 1;
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((rx_cycles % 8) < 5);
        endcase
    end

    // result checker, sampled mid-cycle where inputs are stable
    always @(negedge clk) begin
        link_word_t  w;
        logic [15:0] got [9];
        logic [15:0] want [9];
        string       names [9];
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word multi0=%h", $time, multi0);
                failed = 1'b1;
            end else begin
                w = expected_words.pop_front();
                names = '{"multi0", "multi1", "multi2", "multi3", "send_valid",
                          "send_state", "send_with_data", "payload_word", "last"};
                got  = '{multi0, multi1, multi2, multi3, {15'd0, send_valid},
                         send_state, {15'd0, send_with_data}, payload_word, {15'd0, last}};
                want = '{w.multi[0], w.multi[1], w.multi[2], w.multi[3], {15'd0, w.sv},
                         w.st, {15'd0, w.wd}, w.pw, {15'd0, w.lst}};
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: %s expected %h actual %h", $time, names[i],
                                 want[i], got[i]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    function automatic void push_words(input logic sv, input logic [15:0] st, input logic wd);
        link_word_t w;
        int n;
        n = 1 + ((sv && wd) ? FW : 0);
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 4; j++)
                w.multi[j] = link_reg[j];
            w.sv  = sv;
            w.st  = sv ? st : 16'd0;
            w.wd  = sv && wd;
            w.pw  = (k > 0) ? tx_frame[k - 1] : 16'd0;
            w.lst = (k == n - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic void predict_transfer(input logic [15:0] v);
        int pos;
        logic [15:0] qw;
        link_reg[0] = v;
        if (phase == PH_PREINIT) begin
            if (v != TOK_SLAVE) begin
                push_words(1'b0, 16'd0, 1'b0);
            end else begin
                phase = PH_HANDSHAKE;
                for (int i = 1; i < 4; i++)
                    link_reg[i] = 16'd0;
                push_words(1'b1, {14'd0, PH_HANDSHAKE}, 1'b0);
            end
            return;
        end
        if (phase == PH_HANDSHAKE) begin
            for (int i = 1; i < 4; i++)
                link_reg[i] = (peer_state[i] == {14'd0, PH_HANDSHAKE}) ? TOK_SLAVE
                                                                     : TOK_NOT_READY;
            if (v == TOK_MASTER) begin
                phase = PH_CONNECTED;
                frame_sum = 16'd0;
                frame_pos = 4'd0;
                slave_run = 8'd0;
                for (int i = 1; i < 4; i++) begin
                    q_count[i] = 8'd0;
                    q_head[i]  = 7'd0;
                    if (pkt_open && pkt_peer == i)
                        pkt_open = 1'b0;
                end
            end
            push_words(1'b1, {14'd0, phase}, 1'b0);
            return;
        end
        if (v != TOK_SLAVE) begin
            slave_run = 8'd0;
        end else begin
            if (slave_run < RUN_SAT)
                slave_run++;
            if (slave_run > run_limit) begin
                phase = PH_HANDSHAKE;
                push_words(1'b0, 16'd0, 1'b0);
                return;
            end
        end
        if (frame_pos == 0) begin
            for (int i = 1; i < 4; i++) begin
                link_reg[i] = frame_sum;
                peer_tx[i]  = (q_count[i] > 0);
            end
            frame_pos  = 4'd1;
            frame_sum  = 16'd0;
            tx_nonzero = 1'b0;
            push_words(1'b0, 16'd0, 1'b0);
            return;
        end
        pos = (frame_pos - 1) % FW;
        tx_frame[pos] = v;
        if (v != 0)
            tx_nonzero = 1'b1;
        frame_sum = frame_sum + v;
        for (int i = 1; i < 4; i++) begin
            if (peer_tx[i]) begin
                qw = pkt_store[i][q_head[i]][pos];
                frame_sum = frame_sum + qw;
                link_reg[i] = qw;
            end else begin
                link_reg[i] = 16'd0;
            end
        end
        if (frame_pos < FW) begin
            frame_pos++;
            push_words(1'b0, 16'd0, 1'b0);
            return;
        end
        frame_pos = 4'd0;
        for (int i = 1; i < 4; i++) begin
            if (peer_tx[i] && q_count[i] > 0) begin
                q_count[i]--;
                q_head[i] = q_head[i] + 7'd1;
            end
        end
        push_words(1'b1, {14'd0, PH_CONNECTED}, tx_nonzero);
    endfunction

    function automatic void predict_word(input logic [1:0] op, input logic [15:0] v,
                                         input logic [1:0] pi, input logic [31:0] fl,
                                         input logic [31:0] hw, input logic [15:0] len,
                                         input logic [2:0] wi);
        int tail;
        if (op == OP_XFER) begin
            predict_transfer(v);
        end else if (op == OP_HDR) begin
            if (len == PKT_LEN_BYTES && hw == PKT_MAGIC) begin
                peer_state[pi] = fl[15:0];
                if (pkt_open && pkt_peer == pi)
                    pkt_open = 1'b0;
                if (pi != 0 && fl[31] && q_count[pi] < QD) begin
                    tail = (q_head[pi] + q_count[pi]) % QD;
                    for (int k = 0; k < FW; k++)
                        pkt_store[pi][tail][k] = 16'd0;
                    pkt_open = 1'b1;
                    pkt_peer = pi;
                end
            end
        end else if (op == OP_DATA && pkt_open) begin
            tail = (q_head[pkt_peer] + q_count[pkt_peer]) % QD;
            pkt_store[pkt_peer][tail][wi] = v;
            if (wi == FW - 1) begin
                if (q_count[pkt_peer] < QD)
                    q_count[pkt_peer]++;
                pkt_open = 1'b0;
            end
        end
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [15:0] v,
                             input logic [1:0] pi, input logic [31:0] fl,
                             input logic [31:0] hw, input logic [15:0] len,
                             input logic [2:0] wi);
        int  gap;
        bit  rdy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        opcode        <= op;
        value         <= v;
        peer_index    <= pi;
        flags_word    <= fl;
        header_word   <= hw;
        packet_length <= len;
        word_index    <= wi;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        predict_word(op, v, pi, fl, hw, len, wi);
    endtask

    task automatic xfer(input logic [15:0] v);
        send_word(OP_XFER, v, 2'($urandom), $urandom, $urandom, 16'($urandom),
                  3'($urandom));
    endtask

    task automatic send_packet(input logic [1:0] pi, input logic [15:0] st,
                               input bit shuffle);
        int order [FW];
        int j, t;
        send_word(OP_HDR, 16'($urandom), pi, {1'b1, 15'($urandom), st}, PKT_MAGIC,
                  PKT_LEN_BYTES, 3'($urandom));
        for (int k = 0; k < FW; k++)
            order[k] = k;
        if (shuffle) begin
            for (int k = 0; k < FW - 1; k++) begin
                j = $urandom_range(k, FW - 2);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
        end
        for (int k = 0; k < FW; k++)
            send_word(OP_DATA, 16'($urandom), 2'($urandom), $urandom, $urandom,
                      16'($urandom), 3'(order[k]));
    endtask

    // idle the sender and let the block drain before a register write
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_run_limit(input logic [7:0] lim);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_RUN_LIMIT;
        pwdata  <= {24'($urandom), lim};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        run_limit = lim;
    endtask

    task automatic test_link_bringup;
        xfer(16'h0000);
        xfer(16'hFFFF);
        xfer(TOK_MASTER);
        send_word(OP_HDR, 16'd0, 2'd1, 32'h0000_0001, PKT_MAGIC, PKT_LEN_BYTES, 3'd0);
        send_word(OP_HDR, 16'd0, 2'd2, 32'h8000_0001, PKT_MAGIC, PKT_LEN_BYTES, 3'd0);
        send_word(OP_HDR, 16'd0, 2'd0, 32'h8000_0001, PKT_MAGIC, PKT_LEN_BYTES, 3'd0);
        send_word(OP_HDR, 16'd0, 2'd3, 32'h8000_0001, PKT_MAGIC ^ 32'h1, PKT_LEN_BYTES,
                  3'd0);
        send_word(OP_HDR, 16'd0, 2'd3, 32'h8000_0001, PKT_MAGIC, 16'd41, 3'd0);
        xfer(TOK_SLAVE);
        xfer(16'h1234);
        xfer(TOK_MASTER);
        send_word(OP_DATA, 16'hDEAD, 2'd0, 32'd0, 32'd0, 16'd0, 3'd7);
        send_word(OP_RSVD, 16'hFFFF, 2'd3, 32'hFFFF_FFFF, PKT_MAGIC, PKT_LEN_BYTES, 3'd7);
    endtask

    task automatic test_frames;
        send_packet(2'd1, 16'd2, 1'b0);
        send_packet(2'd2, 16'hFFFF, 1'b1);
        // header restarts a half-sent packet
        send_word(OP_HDR, 16'd0, 2'd3, 32'h8000_0002, PKT_MAGIC, PKT_LEN_BYTES, 3'd0);
        send_word(OP_DATA, 16'h5555, 2'd0, 32'd0, 32'd0, 16'd0, 3'd0);
        send_packet(2'd3, 16'd2, 1'b0);
        for (int k = 0; k < 9; k++)
            xfer(16'($urandom));
        for (int k = 0; k < 9; k++)
            xfer(16'h0000);
        for (int k = 0; k < 9; k++)
            xfer(16'hFFFF);
    endtask

    task automatic test_slave_run(input logic [7:0] lim);
        write_run_limit(lim);
        if (phase != PH_CONNECTED) begin
            xfer(TOK_SLAVE);
            xfer(TOK_MASTER);
        end
        for (int k = 0; k <= lim + 1; k++)
            xfer(TOK_SLAVE);
        xfer(TOK_MASTER);
    endtask

    // several packets wait in one queue and leave one per frame
    task automatic test_queue_backlog;
        if (phase != PH_CONNECTED) begin
            xfer(TOK_SLAVE);
            xfer(TOK_MASTER);
        end
        for (int k = 0; k < 3; k++)
            send_packet(2'd2, 16'($urandom), 1'b0);
        for (int k = 0; k < 27; k++)
            xfer(16'($urandom));
    endtask

    task automatic test_random(input int count);
        int n, r;
        logic [15:0] v;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                r = $urandom_range(0, 19);
                v = (r < 3) ? 16'h0000 : (r < 6) ? TOK_SLAVE :
                    (r < 9) ? TOK_MASTER : 16'($urandom);
                xfer(v);
                n++;
            end else if (r < 75) begin
                send_packet(2'($urandom), ($urandom_range(0, 1) ? 16'($urandom) : 16'd1),
                            1'($urandom_range(0, 1)));
                n += 9;
            end else begin
                send_word(2'($urandom_range(1, 3)), 16'($urandom), 2'($urandom),
                          $urandom, ($urandom_range(0, 2) ? PKT_MAGIC : $urandom),
                          ($urandom_range(0, 2) ? PKT_LEN_BYTES : 16'($urandom)),
                          3'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        failed     = 1'b0;
        burst_left = 0;
        rx_mode    = 0;
        rx_cycles  = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_XFER;
        value      = '0;
        peer_index = '0;
        flags_word = '0;
        header_word = '0;
        packet_length = '0;
        word_index = '0;
        out_ready  = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        run_limit = RUN_LIMIT_RST;
        phase = PH_PREINIT;
        frame_sum = '0;
        frame_pos = '0;
        slave_run = '0;
        tx_nonzero = 1'b0;
        pkt_open = 1'b0;
        pkt_peer = '0;
        for (int i = 0; i < 4; i++) begin
            peer_state[i] = '0;
            q_head[i] = '0;
            q_count[i] = '0;
            peer_tx[i] = 1'b0;
            link_reg[i] = '0;
            for (int s = 0; s < QD; s++)
                for (int k = 0; k < FW; k++)
                    pkt_store[i][s][k] = '0;
        end
        for (int k = 0; k < FW; k++)
            tx_frame[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_link_bringup();
        test_frames();
        test_slave_run(8'd1);
        test_slave_run(8'd255);
        test_queue_backlog();
        write_run_limit(8'd2);
        test_random(40);

        drain();
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mlfm_pkg.sv
sv/mlfm_cfg.sv
sv/mlfm_queue.sv
sv/multiplayer_link_frame_master.sv
sim/tb.sv
